@@ rtl/pts_pkg.sv @@
// Shared types and constants for the preemptive tick scheduler.
// No dependencies; used by pts_picker and the top level.
package pts_pkg;

	// table size and derived widths
	localparam int MAX_TASKS = 64;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int LAST_W    = IDX_W + 1;

	// fixed field widths
	localparam int TIME_W = 32;
	localparam int DONE_W = 7;
	localparam int TC_W   = 7;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [DONE_W-1:0] DONE_MAX = '1;
	localparam logic [LAST_W-1:0] NO_TASK  = '1;

	// item kinds
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// register indexes
	localparam logic REG_POLICY     = 1'b0;
	localparam logic REG_TASK_COUNT = 1'b1;

	// one task table entry
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	// running winner of a scan
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		entry_t           entry;
	} pick_t;

endpackage

@@ rtl/preemptive_tick_scheduler_core.sv @@
// Top level of the preemptive tick scheduler: control, run state, output register.
// Depends on pts_pkg, pts_ram and pts_picker.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata slot/arrival/burst/priority
//  m_*     | out | m_tvalid/m_tready  | m_tuser busy, m_tdata task/time/switched/finished/done
//  cfg_*   | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// A load beat gives no result.
// After a tick beat is taken, s_tready stays low through the scan: one table read per
// cycle for task_count entries (capped at MAX_TASKS; none with no tasks), the read
// latency, closing the scan, then the write-back.
// The result register lets the next beat enter while a result waits; a tick
// holds in write-back while the previous result is not taken.
// Reset clears the run state and control; table contents are undefined until loaded.
module preemptive_tick_scheduler_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [47:0]               s_tdata,  // slot[5:0], arrival[21:6],
	                                            // burst[37:22], priority_req[45:38]
	input  logic                      s_tuser,  // mode[0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,  // running_task[5:0], slot_time[37:6],
	                                            // switched[38], finished[39], all_done[40]
	output logic                      m_tuser,  // busy_res[0]
	input  logic                      cfg_we,
	input  logic                      cfg_addr,
	input  logic [pts_pkg::TC_W-1:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WB   = 3'b100
	} state_t;

	state_t                        state_q;
	logic                          policy_q;
	logic [pts_pkg::TC_W-1:0]      task_count_q;
	logic [pts_pkg::TIME_W-1:0]    current_time_q;
	logic [pts_pkg::LAST_W-1:0]    last_task_q;
	logic [pts_pkg::DONE_W-1:0]    done_cnt_q;
	logic [pts_pkg::CNT_W-1:0]     cnt_q;
	logic [pts_pkg::CNT_W-1:0]     rd_idx_q;
	logic                          rd_vld_s1;
	logic [pts_pkg::IDX_W-1:0]     idx_s1;

	logic                          in_fire;
	logic                          load_fire;
	logic                          tick_fire;
	logic                          out_stall;
	logic                          wb_go;
	logic [5:0]                    in_slot;
	pts_pkg::entry_t               in_entry;
	logic [pts_pkg::CNT_W-1:0]     eff_cnt;
	logic                          issue;

	logic                          ram_we;
	logic [pts_pkg::IDX_W-1:0]     ram_waddr;
	pts_pkg::entry_t               ram_wdata;
	pts_pkg::entry_t               ram_rdata;
	pts_pkg::pick_t                best;

	logic [15:0]                   rem_dec;
	logic                          fin;
	logic                          sw;
	logic [pts_pkg::DONE_W-1:0]    done_next;
	logic                          all_done;

	// input decode: arrival, remaining, prio from the top bit down
	assign in_slot  = s_tdata[5:0];
	assign in_entry = {s_tdata[21:6], s_tdata[37:22], s_tdata[45:38]};

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign load_fire = in_fire && (s_tuser == pts_pkg::MODE_LOAD);
	assign tick_fire = in_fire && (s_tuser == pts_pkg::MODE_TICK);
	assign out_stall = m_tvalid && !m_tready;
	assign wb_go     = (state_q == ST_WB) && !out_stall;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);

	// task_count capped at the table size
	assign eff_cnt = (32'(task_count_q) > pts_pkg::MAX_TASKS)
		? pts_pkg::CNT_W'(pts_pkg::MAX_TASKS) : pts_pkg::CNT_W'(task_count_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= 1'b1;
			task_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pts_pkg::REG_POLICY:     policy_q     <= cfg_wdata[0];
				pts_pkg::REG_TASK_COUNT: task_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (tick_fire) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						cnt_q    <= eff_cnt;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// slot index is registered to line up with the registered read data
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[pts_pkg::IDX_W-1:0];
	end

	// task table
	assign rem_dec = best.entry.remaining - 16'd1;
	always_comb begin
		if (state_q == ST_WB) begin
			ram_we              = wb_go && best.found;
			ram_waddr           = best.idx;
			ram_wdata           = best.entry;
			ram_wdata.remaining = rem_dec;
		end else begin
			ram_we    = load_fire && (32'(in_slot) < pts_pkg::MAX_TASKS);
			ram_waddr = pts_pkg::IDX_W'(in_slot);
			ram_wdata = in_entry;
		end
	end

	pts_ram #(
		.WIDTH($bits(pts_pkg::entry_t)),
		.DEPTH(pts_pkg::MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[pts_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	pts_picker u_picker (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (tick_fire),
		.vld    (rd_vld_s1),
		.idx    (idx_s1),
		.entry  (ram_rdata),
		.policy (policy_q),
		.now    (current_time_q),
		.best   (best)
	);

	// write-back results
	always_comb begin
		fin = best.found && (rem_dec == 16'd0);
		sw  = best.found && (pts_pkg::LAST_W'(best.idx) != last_task_q);
		if (fin && (done_cnt_q != pts_pkg::DONE_MAX)) begin
			done_next = done_cnt_q + 1'b1;
		end else begin
			done_next = done_cnt_q;
		end
		all_done = 32'(done_next) >= 32'(cnt_q);
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_time_q <= '0;
			last_task_q    <= pts_pkg::NO_TASK;
			done_cnt_q     <= '0;
		end else if (load_fire) begin
			current_time_q <= '0;
			last_task_q    <= pts_pkg::NO_TASK;
			done_cnt_q     <= '0;
		end else if (wb_go) begin
			if (current_time_q != pts_pkg::TIME_MAX) begin
				current_time_q <= current_time_q + 1'b1;
			end
			if (best.found) begin
				last_task_q <= pts_pkg::LAST_W'(best.idx);
			end
			done_cnt_q <= done_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (wb_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			m_tuser <= best.found;
			m_tdata <= {7'd0, all_done, fin, sw, current_time_q,
				best.found ? 6'(best.idx) : 6'd0};
		end
	end

	// checks
	a_wb_write_needs_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != ST_IDLE)) |-> (best.found && (state_q == ST_WB)))
		else $error("table write-back without a winner");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= cnt_q))
		else $error("scan index beyond task count");

	a_wb_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> (state_q == ST_IDLE) && m_tvalid)
		else $error("write-back did not post a result");

	a_idle_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (!m_tdata[38] && !m_tdata[39] && (m_tdata[5:0] == 6'd0)))
		else $error("idle tick reports a task");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> !$past(in_fire))
		else $error("beat accepted during a scan");

endmodule

@@ rtl/pts_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/pts_picker.sv @@
// Winner tracking for one tick scan: takes one table entry a cycle.
// Depends on pts_pkg.
module pts_picker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       vld,
	input  logic [pts_pkg::IDX_W-1:0]  idx,
	input  pts_pkg::entry_t            entry,
	input  logic                       policy,
	input  logic [pts_pkg::TIME_W-1:0] now,
	output pts_pkg::pick_t             best
);

	logic                      found_q;
	logic [pts_pkg::IDX_W-1:0] idx_q;
	pts_pkg::entry_t           entry_q;
	logic                      ready;
	logic                      wins;

	// arrived with work left, then compare against the current winner
	always_comb begin
		ready = (pts_pkg::TIME_W'(entry.arrival) <= now) && (entry.remaining != 16'd0);
		if (!found_q) begin
			wins = 1'b1;
		end else if (policy) begin
			wins = entry.prio > entry_q.prio;
		end else begin
			wins = entry.remaining > entry_q.remaining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (vld && ready && wins) begin
			found_q <= 1'b1;
		end
	end

	// winner payload, strict compare keeps the lowest slot on ties
	always_ff @(posedge clk) begin
		if (!clr && vld && ready && wins) begin
			idx_q   <= idx;
			entry_q <= entry;
		end
	end

	assign best = '{found: found_q, idx: idx_q, entry: entry_q};

endmodule
